// ----- design/llrb_pkg.sv -----
// Shared types, constants and codes for the last-lines ring buffer.
package llrb_pkg;

    localparam int DEF_LINE_SLOTS = 64;
    localparam int DEF_LINE_BYTES = 512;

    localparam int KEEP_W = 7;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOS  = 2'd1;
    localparam logic [1:0] KIND_PULL = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       done_res;
    } result_t;

    typedef struct packed {
        logic data_wr;
        logic eos_commit;
        logic eos_set;
        logic pull_read;
        logic pull_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ended;
    } ctrl_status_t;

endpackage

// ----- design/llrb_ctrl.sv -----
// Controller state machine that sequences data, end-of-stream and pull transactions.
module llrb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  llrb_pkg::ctrl_status_t status,
    output logic                  busy,
    output llrb_pkg::ctrl_cmd_t   cmd
);
    import llrb_pkg::*;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_EOS_FIN  = 2'd1;
    localparam logic [1:0] ST_PULL_OUT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_DATA:
                        begin
                            cmd.data_wr = 1'b1;
                        end
                        KIND_EOS:
                        begin
                            if (!status.ended)
                            begin
                                cmd.eos_commit = 1'b1;
                                state_next     = ST_EOS_FIN;
                            end
                        end
                        KIND_PULL:
                        begin
                            cmd.pull_read = 1'b1;
                            state_next    = ST_PULL_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EOS_FIN:
            begin
                cmd.eos_set = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PULL_OUT:
            begin
                cmd.pull_out = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_pull_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULL_OUT) |=> (state_reg == ST_IDLE))
        else $error("pull output state lasted more than one cycle");

    a_eos_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eos_commit |-> !status.ended)
        else $error("end of stream sequenced after stream already ended");

    a_accept_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.data_wr || cmd.eos_commit || cmd.pull_read) |-> (state_reg == ST_IDLE))
        else $error("transaction started while busy");

endmodule

// ----- design/llrb_datapath.sv -----
// Datapath: line store, line length table, ring pointers and readout registers.
module llrb_datapath #(
    parameter int LINE_SLOTS = llrb_pkg::DEF_LINE_SLOTS,
    parameter int LINE_BYTES = llrb_pkg::DEF_LINE_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  llrb_pkg::ctrl_cmd_t         cmd,
    input  llrb_pkg::item_t             item,
    input  logic                        cfg_we,
    input  logic [llrb_pkg::KEEP_W-1:0] cfg_data,
    output llrb_pkg::ctrl_status_t      status,
    output llrb_pkg::result_t           result,
    output logic                        result_valid
);
    import llrb_pkg::*;

    localparam int SW    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int CW    = $clog2(LINE_SLOTS + 1);
    localparam int LW    = $clog2(LINE_BYTES);
    localparam int DEPTH = LINE_SLOTS * LINE_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (CW > KEEP_W) ? CW : KEEP_W;
    localparam int DW    = CW + 1;

    localparam logic [SW-1:0] LAST_SLOT = SW'(LINE_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT  = CW'(LINE_SLOTS);
    localparam logic [LW-1:0] MAX_LEN   = LW'(LINE_BYTES - 1);
    localparam logic [DW-1:0] SLOT_WRAP = DW'(LINE_SLOTS);

    logic [7:0]        store_mem [DEPTH];
    logic [LW-1:0]     len_mem   [LINE_SLOTS];

    logic [KEEP_W-1:0] keep_reg;
    logic [SW-1:0]     head_reg;
    logic [CW-1:0]     stored_reg;
    logic [LW-1:0]     cur_len_reg;
    logic              ended_reg;
    logic [CW-1:0]     left_reg;
    logic [SW-1:0]     rd_slot_reg;
    logic [LW-1:0]     rd_off_reg;

    logic [7:0]        byte_q_reg;
    logic [LW-1:0]     len_q_reg;
    logic              pull_done_reg;
    result_t           result_reg;
    logic              result_valid_reg;

    logic              data_ok;
    logic              byte_kept;
    logic [LW-1:0]     len_after;
    logic              commit;
    logic [LW-1:0]     commit_len;
    logic [SW-1:0]     head_inc;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [EW-1:0]     keep_ext;
    logic [EW-1:0]     stored_ext;
    logic [CW-1:0]     emit;
    logic [DW-1:0]     head_ext;
    logic [DW-1:0]     emit_ext;
    logic [DW-1:0]     start_slot;
    logic [LW:0]       off_inc;
    logic              line_end;
    logic [CW-1:0]     left_next;
    logic [SW-1:0]     rd_slot_inc;

    assign data_ok    = cmd.data_wr && !ended_reg;
    assign byte_kept  = (cur_len_reg < MAX_LEN);
    assign len_after  = byte_kept ? (cur_len_reg + LW'(1)) : cur_len_reg;
    assign commit     = (data_ok && (item.data_byte == NEWLINE))
                     || (cmd.eos_commit && (cur_len_reg != '0));
    assign commit_len = cmd.data_wr ? len_after : cur_len_reg;
    assign head_inc   = (head_reg == LAST_SLOT) ? '0 : (head_reg + SW'(1));

    assign wr_addr = AW'(head_reg * LINE_BYTES) + AW'(cur_len_reg);
    assign rd_addr = AW'(rd_slot_reg * LINE_BYTES) + AW'(rd_off_reg);

    assign keep_ext   = EW'(keep_reg);
    assign stored_ext = EW'(stored_reg);
    assign emit       = (keep_ext < stored_ext) ? CW'(keep_ext) : stored_reg;
    assign head_ext   = DW'(head_reg);
    assign emit_ext   = DW'(emit);
    assign start_slot = (head_ext >= emit_ext) ? (head_ext - emit_ext)
                                               : (head_ext + SLOT_WRAP - emit_ext);

    assign off_inc     = {1'b0, rd_off_reg} + (LW+1)'(1);
    assign line_end    = (off_inc >= {1'b0, len_q_reg});
    assign left_next   = line_end ? (left_reg - CW'(1)) : left_reg;
    assign rd_slot_inc = (rd_slot_reg == LAST_SLOT) ? '0 : (rd_slot_reg + SW'(1));

    assign status.ended = ended_reg;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk)
    begin
        if (data_ok && byte_kept)
        begin
            store_mem[wr_addr] <= item.data_byte;
        end
        if (cmd.pull_read)
        begin
            byte_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            len_mem[head_reg] <= commit_len;
        end
        if (cmd.pull_read)
        begin
            len_q_reg <= len_mem[rd_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg         <= KEEP_RESET;
            head_reg         <= '0;
            stored_reg       <= '0;
            cur_len_reg      <= '0;
            ended_reg        <= 1'b0;
            left_reg         <= '0;
            rd_slot_reg      <= '0;
            rd_off_reg       <= '0;
            pull_done_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.pull_out;
            if (cfg_we)
            begin
                keep_reg <= cfg_data;
            end
            if (data_ok)
            begin
                cur_len_reg <= len_after;
            end
            if (commit)
            begin
                head_reg    <= head_inc;
                cur_len_reg <= '0;
                if (stored_reg < SLOT_CNT)
                begin
                    stored_reg <= stored_reg + CW'(1);
                end
            end
            if (cmd.eos_set)
            begin
                ended_reg   <= 1'b1;
                left_reg    <= emit;
                rd_slot_reg <= SW'(start_slot);
                rd_off_reg  <= '0;
            end
            if (cmd.pull_read)
            begin
                pull_done_reg <= !ended_reg || (left_reg == '0);
            end
            if (cmd.pull_out && !pull_done_reg)
            begin
                left_reg <= left_next;
                if (line_end)
                begin
                    rd_off_reg  <= '0;
                    rd_slot_reg <= rd_slot_inc;
                end
                else
                begin
                    rd_off_reg <= off_inc[LW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pull_out)
        begin
            if (pull_done_reg)
            begin
                result_reg.out_byte  <= '0;
                result_reg.last_byte <= 1'b0;
                result_reg.done_res  <= 1'b1;
            end
            else
            begin
                result_reg.out_byte  <= byte_q_reg;
                result_reg.last_byte <= (left_next == '0);
                result_reg.done_res  <= 1'b0;
            end
        end
    end

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= SLOT_CNT)
        else $error("stored line count exceeds slot count");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= stored_reg)
        else $error("lines left to read exceed stored lines");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= MAX_LEN)
        else $error("current line length exceeds slot capacity");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.done_res && result_reg.last_byte))
        else $error("result flagged both done and last");

endmodule

// ----- design/last_lines_ring_buffer.sv -----
// Top level of the last-lines ring buffer: controller plus datapath.
//
// Command channel: a transaction is accepted on a rising edge with start high and
// busy low. Kind data writes one text byte, kind end-of-stream closes the input,
// and kind pull asks for the next retained output byte. Kind three is ignored.
// A data byte does not raise busy, so bytes can stream in back to back.
// End of stream on an open stream and pull each raise busy after the accepting
// edge; a pull does the registered read of the line store and length table at
// that edge, and the busy state registers the result or, after end of stream,
// updates the pointers. A pull result appears on result with result_valid high
// for exactly one cycle, starting at the edge where busy falls; the receiver
// cannot stall it, and a new transaction may be accepted while that result is shown.
// The configuration channel writes keep_lines whenever cfg_valid is high, since
// cfg_ready is always high; it is sampled at end of stream.
// Reset clears the pointers, counters and flags and sets keep_lines to ten.
// The line store and length table are not cleared; only written slots are read.
module last_lines_ring_buffer #(
    parameter int LINE_SLOTS = llrb_pkg::DEF_LINE_SLOTS,
    parameter int LINE_BYTES = llrb_pkg::DEF_LINE_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  llrb_pkg::item_t             cmd,
    output llrb_pkg::result_t           result,
    output logic                        result_valid,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [llrb_pkg::KEEP_W-1:0] cfg_data
);
    import llrb_pkg::*;

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;

    assign cfg_ready = 1'b1;

    llrb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (cmd.kind),
        .status (ctrl_status),
        .busy   (busy),
        .cmd    (ctrl_cmd)
    );

    llrb_datapath #(
        .LINE_SLOTS (LINE_SLOTS),
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .item         (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .status       (ctrl_status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
